// ===== sv/ptdr_pkg.sv =====
// Shared constants, register indexes and controller/datapath bundles for the pattern replacer.
package ptdr_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int MAX_DIGITS  = 10;
	localparam int BYTE_W      = 8;
	localparam int CFG_W       = 64;
	localparam int IDX_W       = 2;
	localparam int LEN_FIELD_W = 4;
	localparam int VAL_W       = 31;
	localparam int DIG_W       = 4;
	localparam int DCNT_W      = $clog2(MAX_DIGITS);
	localparam int CONV_STEPS  = VAL_W;
	localparam int CONV_W      = $clog2(CONV_STEPS);

	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

	typedef enum logic [IDX_W-1:0] {
		REG_LEN = 2'd0,
		REG_PAT = 2'd1,
		REG_VAL = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic match;
		logic pass;
		logic conv;
		logic dig_emit;
		logic fl_emit;
	} cmd_t;

	typedef struct packed {
		logic ov_free;
		logic full;
		logic match;
		logic eot;
		logic conv_start;
		logic conv_done;
		logic dig_last;
		logic fl_last;
	} status_t;

endpackage

// ===== sv/ptdr_ctrl.sv =====
// Controller state machine: input acceptance, digit emission, flush and value conversion.
module ptdr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ptdr_pkg::status_t st,
	output ptdr_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CONV  = 4'b0010,
		ST_DIG   = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   take;

	assign in_ready = (state_q == ST_IDLE) && st.ov_free && !st.conv_start;
	assign take     = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (st.conv_start) begin
					state_d = ST_CONV;
				end else if (take) begin
					cmd.load = 1'b1;
					if (st.match) begin
						cmd.match = 1'b1;
						state_d   = ST_DIG;
					end else if (st.full && !st.eot) begin
						cmd.pass = 1'b1;
					end else if (st.eot) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
				if (st.conv_done)
					state_d = ST_IDLE;
			end
			ST_DIG: begin
				if (st.ov_free) begin
					cmd.dig_emit = 1'b1;
					if (st.dig_last)
						state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (st.ov_free) begin
					cmd.fl_emit = 1'b1;
					if (st.fl_last)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== sv/ptdr_dp.sv =====
// Datapath: config registers, byte window, decimal digit store and output register.
module ptdr_dp #(
	parameter int MAX_PATTERN = ptdr_pkg::MAX_PATTERN
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ptdr_pkg::cmd_t                   cmd,
	output ptdr_pkg::status_t                st,
	input  logic [ptdr_pkg::BYTE_W-1:0]      data_byte,
	input  logic                             end_of_text,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ptdr_pkg::BYTE_W-1:0]      out_byte,
	output logic                             out_last,
	input  logic                             cfg_we,
	input  logic [ptdr_pkg::IDX_W-1:0]       cfg_index,
	input  logic [ptdr_pkg::CFG_W-1:0]       cfg_data
);

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int PAT_W = MAX_PATTERN * ptdr_pkg::BYTE_W;
	localparam int BW    = ptdr_pkg::BYTE_W;

	logic [CNT_W-1:0]                  len_q, held_q, len_d;
	logic [PAT_W-1:0]                  pat_q;
	logic [BW-1:0]                     win_q   [MAX_PATTERN];
	logic [BW-1:0]                     win_new [MAX_PATTERN];
	logic [ptdr_pkg::VAL_W-1:0]        bin_q;
	logic [ptdr_pkg::DIG_W-1:0]        bcd_q   [ptdr_pkg::MAX_DIGITS];
	logic [ptdr_pkg::DIG_W-1:0]        bcd_adj [ptdr_pkg::MAX_DIGITS];
	logic [ptdr_pkg::DIG_W-1:0]        bcd_nx  [ptdr_pkg::MAX_DIGITS];
	logic [ptdr_pkg::DCNT_W-1:0]       dcount_q, dcount_nx, idx_q;
	logic [ptdr_pkg::CONV_W-1:0]       conv_cnt_q;
	logic                              eot_q;
	logic                              out_valid_q, out_last_q;
	logic [BW-1:0]                     out_byte_q;
	logic [ptdr_pkg::LEN_FIELD_W-1:0]  lv;
	logic                              cmp_ok, emit;

	// length clamp
	always_comb begin
		lv = cfg_data[ptdr_pkg::LEN_FIELD_W-1:0];
		if (lv == '0)
			len_d = CNT_W'(1);
		else if (lv > ptdr_pkg::LEN_FIELD_W'(MAX_PATTERN))
			len_d = CNT_W'(MAX_PATTERN);
		else
			len_d = CNT_W'(lv);
	end

	// window with the incoming byte placed, and pattern compare
	always_comb begin
		cmp_ok = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			win_new[i] = (held_q == CNT_W'(i)) ? data_byte : win_q[i];
			if ((CNT_W'(i) < len_q) && (win_new[i] != pat_q[BW*i +: BW]))
				cmp_ok = 1'b0;
		end
	end

	// one double-dabble step
	always_comb begin
		for (int i = 0; i < ptdr_pkg::MAX_DIGITS; i++)
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		bcd_nx[0] = {bcd_adj[0][2:0], bin_q[ptdr_pkg::VAL_W-1]};
		for (int i = 1; i < ptdr_pkg::MAX_DIGITS; i++)
			bcd_nx[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
		dcount_nx = ptdr_pkg::DCNT_W'(1);
		for (int i = 1; i < ptdr_pkg::MAX_DIGITS; i++)
			if (bcd_nx[i] != '0)
				dcount_nx = ptdr_pkg::DCNT_W'(i + 1);
	end

	assign emit = cmd.pass || cmd.dig_emit || cmd.fl_emit;

	always_comb begin
		st.ov_free    = !out_valid_q || out_ready;
		st.full       = (held_q + CNT_W'(1)) == len_q;
		st.match      = st.full && cmp_ok;
		st.eot        = end_of_text;
		st.conv_start = cfg_we && (cfg_index == ptdr_pkg::REG_VAL);
		st.conv_done  = conv_cnt_q == ptdr_pkg::CONV_W'(ptdr_pkg::CONV_STEPS - 1);
		st.dig_last   = idx_q == '0;
		st.fl_last    = held_q == CNT_W'(1);
	end

	// control and config state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= CNT_W'(1);
			pat_q       <= '0;
			held_q      <= '0;
			dcount_q    <= ptdr_pkg::DCNT_W'(1);
			conv_cnt_q  <= '0;
			idx_q       <= '0;
			eot_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ptdr_pkg::MAX_DIGITS; i++)
				bcd_q[i] <= '0;
		end else begin
			if (cfg_we && cfg_index == ptdr_pkg::REG_LEN) begin
				len_q  <= len_d;
				held_q <= '0;
			end
			if (cfg_we && cfg_index == ptdr_pkg::REG_PAT)
				pat_q <= cfg_data[PAT_W-1:0];
			if (st.conv_start) begin
				conv_cnt_q <= '0;
				for (int i = 0; i < ptdr_pkg::MAX_DIGITS; i++)
					bcd_q[i] <= '0;
			end else if (cmd.conv) begin
				conv_cnt_q <= conv_cnt_q + 1'b1;
				bcd_q      <= bcd_nx;
				if (st.conv_done)
					dcount_q <= dcount_nx;
			end
			if (cmd.load) begin
				if (cmd.match) begin
					held_q <= '0;
					idx_q  <= dcount_q - 1'b1;
					eot_q  <= end_of_text;
				end else if (!cmd.pass) begin
					held_q <= held_q + CNT_W'(1);
				end
			end
			if (cmd.dig_emit)
				idx_q <= idx_q - 1'b1;
			if (cmd.fl_emit)
				held_q <= held_q - CNT_W'(1);
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (st.conv_start)
			bin_q <= cfg_data[ptdr_pkg::VAL_W-1:0];
		else if (cmd.conv)
			bin_q <= {bin_q[ptdr_pkg::VAL_W-2:0], 1'b0};
		if (cmd.load && !cmd.match) begin
			if (cmd.pass) begin
				for (int i = 0; i < MAX_PATTERN - 1; i++)
					win_q[i] <= win_new[i+1];
			end else begin
				win_q <= win_new;
			end
		end
		if (cmd.fl_emit)
			for (int i = 0; i < MAX_PATTERN - 1; i++)
				win_q[i] <= win_q[i+1];
		if (cmd.pass) begin
			out_byte_q <= win_new[0];
			out_last_q <= 1'b0;
		end else if (cmd.dig_emit) begin
			out_byte_q <= ptdr_pkg::ASCII_ZERO + BW'(bcd_q[idx_q]);
			out_last_q <= eot_q && (idx_q == '0);
		end else if (cmd.fl_emit) begin
			out_byte_q <= win_q[0];
			out_last_q <= held_q == CNT_W'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

// ===== sv/pattern_to_decimal_replace.sv =====
// Top level of the streaming pattern-to-decimal replacer.
// Usage:
//   Input channel (in_valid/in_ready, data_byte, end_of_text) takes one word per cycle.
//   Output channel (out_valid/out_ready, out_byte, out_last) gives rewritten text.
//   cfg_we/cfg_index/cfg_data write pattern length (0), pattern bytes (1) and the
//   replacement value (2) while the block is idle (a rule for the user, not enforced).
//   Up to pattern-length minus one words are held back; once the window is full and
//   does not match, each accepted word releases its oldest byte to the output register,
//   so plain text streams at one word per cycle while the receiver does not stall.
//   A match takes the word, then emits one digit per unstalled cycle (1 to 10),
//   input held off meanwhile. A final word flushes the held bytes the same way.
//   A write of the replacement value starts a binary-to-decimal conversion
//   (one shift-add-3 step per cycle); in_ready stays low until it ends.
//   When the receiver stalls, the output register holds its word and in_ready drops.
//   Reset empties the window, sets length 1, pattern 0 and value 0 (digit "0").
module pattern_to_decimal_replace #(
	parameter int MAX_PATTERN = ptdr_pkg::MAX_PATTERN
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ptdr_pkg::BYTE_W-1:0]  data_byte,
	input  logic                         end_of_text,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ptdr_pkg::BYTE_W-1:0]  out_byte,
	output logic                         out_last,
	input  logic                         cfg_we,
	input  logic [ptdr_pkg::IDX_W-1:0]   cfg_index,
	input  logic [ptdr_pkg::CFG_W-1:0]   cfg_data
);

	ptdr_pkg::cmd_t    cmd;
	ptdr_pkg::status_t st;

	ptdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	ptdr_dp #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.data_byte   (data_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.out_last    (out_last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

endmodule

// ===== sv/ptdr_checker.sv =====
// Port-level checks for the pattern replacer, bound to the top level.
module ptdr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         end_of_text,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [ptdr_pkg::BYTE_W-1:0]  out_byte,
	input logic                         out_last,
	input logic                         cfg_we,
	input logic [ptdr_pkg::IDX_W-1:0]   cfg_index
);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output word changed while stalled");

	// no new word while output stalled
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// value write starts conversion
	a_conv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == ptdr_pkg::REG_VAL) |=> !in_ready)
		else $error("input ready during conversion");

	// final word always starts a flush or digit run
	a_eot_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_text |=> !in_ready)
		else $error("input ready right after final word");

endmodule

bind pattern_to_decimal_replace ptdr_checker u_ptdr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.end_of_text (end_of_text),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_byte    (out_byte),
	.out_last    (out_last),
	.cfg_we      (cfg_we),
	.cfg_index   (cfg_index)
);
